// File: src/lnt_pkg.sv
// Shared constants and types for the lattice noise turbulence core.
package lnt_pkg;

    localparam int HASH_ENTRIES = 4096;
    localparam int HASH_AW      = $clog2(HASH_ENTRIES);
    localparam int GRAD_ENTRIES = 267;
    localparam int GRAD_AW      = $clog2(GRAD_ENTRIES);
    localparam int MAX_OCTAVES  = 8;

    localparam int PERM_W = 12;
    localparam int GRAD_W = 16;

    localparam logic [1:0] OP_LOAD_PERM = 2'd0;
    localparam logic [1:0] OP_LOAD_GRAD = 2'd1;
    localparam logic [1:0] OP_EVALUATE  = 2'd2;

    localparam logic [1:0] REG_VECTOR_MODE    = 2'd0;
    localparam logic [1:0] REG_OCTAVE_COUNT   = 2'd1;
    localparam logic [1:0] REG_FREQUENCY_GAIN = 2'd2;
    localparam logic [1:0] REG_AMPLITUDE_GAIN = 2'd3;

    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_HALF       = 32'h0000_8000;
    localparam logic [49:0] POINT_OFFSET = 50'd655360000;
    localparam logic [30:0] POINT_MAX    = 31'h7FFF_FFFF;
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;

    localparam logic [23:0] FREQ_RESET = 24'd131072;
    localparam logic [23:0] AMP_RESET  = 24'd32768;

    typedef logic signed [32:0] t_mul_op;
    typedef logic signed [65:0] t_mul_res;

endpackage

// File: src/lattice_noise_turbulence_3d_core.sv
// Top level of the lattice gradient noise turbulence core.
//
// Input stream (s_axis): tuser carries the opcode. Load requests write one
// entry of the permutation or gradient memory in the cycle they are taken.
// An evaluate request runs a sequencer over all octaves and produces one
// result on m_axis; loads and unused opcodes produce none.
// The sequencer reads both memories (registered read) and shares a
// single registered 33x33 multiplier, so each step waits for the last.
// Per octave: each axis is scaled, squared and smoothed; then for each of
// 8 corners three permutation lookups pick gradient entries, and a
// weighted dot product is accumulated per component (1 scalar, 3 vector);
// then each component is scaled by the amplitude and the gains advance.
// The input is ready only while the sequencer is idle.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver still stalls when the following result
// is done, the sequencer holds until the register frees.
// Reset clears control and configuration; memory contents stay undefined
// until written. Configuration is written through the APB port.
module lattice_noise_turbulence_3d_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // table_index[11:0], hash_value[23:12], gradient_value[39:24],
    // point_x[71:40], point_y[103:72], point_z[135:104]
    input  logic [135:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_x[31:0], result_y[63:32], result_z[95:64]
    output logic [95:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SCALE   = 5'd1;
    localparam logic [4:0] S_SCALE_W = 5'd2;
    localparam logic [4:0] S_SQ      = 5'd3;
    localparam logic [4:0] S_SQ_W    = 5'd4;
    localparam logic [4:0] S_SM      = 5'd5;
    localparam logic [4:0] S_SM_W    = 5'd6;
    localparam logic [4:0] S_CORNER  = 5'd7;
    localparam logic [4:0] S_H1      = 5'd8;
    localparam logic [4:0] S_H2      = 5'd9;
    localparam logic [4:0] S_H3      = 5'd10;
    localparam logic [4:0] S_GRD     = 5'd11;
    localparam logic [4:0] S_WD      = 5'd12;
    localparam logic [4:0] S_WACC    = 5'd13;
    localparam logic [4:0] S_OMUL    = 5'd14;
    localparam logic [4:0] S_OACC    = 5'd15;
    localparam logic [4:0] S_LMUL    = 5'd16;
    localparam logic [4:0] S_LUPD    = 5'd17;
    localparam logic [4:0] S_GMUL    = 5'd18;
    localparam logic [4:0] S_GUPD    = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;

    logic [4:0]  r_state;
    logic [4:0]  n_state;

    logic        r_vector_mode;
    logic [3:0]  r_octave_count;
    logic [23:0] r_freq_gain;
    logic [23:0] r_amp_gain;

    logic signed [31:0] r_p [3];
    logic [31:0]        r_l;
    logic [31:0]        r_o;
    logic [3:0]         r_oct_left;
    logic signed [47:0] r_acc [3];
    logic [14:0]        r_cell [3];
    logic [15:0]        r_frac [3];
    logic [16:0]        r_s [3];
    logic [15:0]        r_f2;
    logic [1:0]         r_axis;
    logic [2:0]         r_corner;
    logic [1:0]         r_comp;
    logic [2:0]         r_gi;
    logic [16:0]        r_w;
    logic signed [19:0] r_d;
    logic signed [23:0] r_res [3];
    logic [7:0]         r_base;
    lnt_pkg::t_mul_res  r_prod;

    logic               r_out_valid;
    logic [95:0]        r_out_data;

    logic               in_fire;
    logic               out_free;
    logic               cfg_write;
    logic [1:0]         in_op;
    logic [11:0]        in_idx;

    lnt_pkg::t_mul_op   mul_a;
    lnt_pkg::t_mul_op   mul_b;

    logic                        perm_we;
    logic [lnt_pkg::HASH_AW-1:0] perm_raddr;
    logic [lnt_pkg::PERM_W-1:0]  perm_rdata;
    logic                        grad_we;
    logic [lnt_pkg::GRAD_AW-1:0] grad_raddr;
    logic [lnt_pkg::GRAD_W-1:0]  grad_rdata;

    logic [15:0]        cell_sum [3];
    logic [15:0]        hash_x1;
    logic [15:0]        hash_x2;
    logic signed [49:0] scaled;
    logic signed [23:0] noise_n;
    logic signed [24:0] noise_half;
    logic [1:0]         off_axis;
    logic [3:0]         oct_start;

    function automatic logic [16:0] corner_wt(input logic [16:0] s, input logic hi);
        return hi ? s : 17'(lnt_pkg::Q_ONE - {15'd0, s});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] sat_gain(input lnt_pkg::t_mul_res v);
        return (v[65:48] != 18'd0) ? 32'hFFFF_FFFF : v[47:16];
    endfunction

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_op     = s_axis_tuser;
    assign in_idx    = s_axis_tdata[11:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;

    always_comb begin
        case (paddr[3:2])
            lnt_pkg::REG_VECTOR_MODE:    prdata = {31'd0, r_vector_mode};
            lnt_pkg::REG_OCTAVE_COUNT:   prdata = {28'd0, r_octave_count};
            lnt_pkg::REG_FREQUENCY_GAIN: prdata = {8'd0, r_freq_gain};
            lnt_pkg::REG_AMPLITUDE_GAIN: prdata = {8'd0, r_amp_gain};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_mode  <= 1'b0;
            r_octave_count <= 4'd1;
            r_freq_gain    <= lnt_pkg::FREQ_RESET;
            r_amp_gain     <= lnt_pkg::AMP_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                lnt_pkg::REG_VECTOR_MODE:    r_vector_mode  <= pwdata[0];
                lnt_pkg::REG_OCTAVE_COUNT:   r_octave_count <= pwdata[3:0];
                lnt_pkg::REG_FREQUENCY_GAIN: r_freq_gain    <= pwdata[23:0];
                lnt_pkg::REG_AMPLITUDE_GAIN: r_amp_gain     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    assign perm_we = in_fire && (in_op == lnt_pkg::OP_LOAD_PERM)
                     && (32'(in_idx) < lnt_pkg::HASH_ENTRIES);
    assign grad_we = in_fire && (in_op == lnt_pkg::OP_LOAD_GRAD)
                     && (32'(in_idx) < lnt_pkg::GRAD_ENTRIES);

    lnt_ram #(
        .WIDTH (lnt_pkg::PERM_W),
        .DEPTH (lnt_pkg::HASH_ENTRIES)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr ((lnt_pkg::HASH_AW)'(in_idx)),
        .i_wdata (s_axis_tdata[23:12]),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    lnt_ram #(
        .WIDTH (lnt_pkg::GRAD_W),
        .DEPTH (lnt_pkg::GRAD_ENTRIES)
    ) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (grad_we),
        .i_waddr ((lnt_pkg::GRAD_AW)'(in_idx)),
        .i_wdata (s_axis_tdata[39:24]),
        .i_raddr (grad_raddr),
        .o_rdata (grad_rdata)
    );

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cell_sum[a] = {1'b0, r_cell[a]} + {15'd0, r_corner[a]};
        end
    end

    assign hash_x1 = {4'd0, perm_rdata} ^ cell_sum[1];
    assign hash_x2 = {4'd0, perm_rdata} ^ cell_sum[2];

    always_comb begin
        case (r_state)
            S_CORNER: perm_raddr = cell_sum[0][lnt_pkg::HASH_AW-1:0];
            S_H1:     perm_raddr = hash_x1[lnt_pkg::HASH_AW-1:0];
            S_H2:     perm_raddr = hash_x2[lnt_pkg::HASH_AW-1:0];
            default:  perm_raddr = '0;
        endcase
    end

    assign grad_raddr = (lnt_pkg::GRAD_AW)'({1'b0, r_base} + {5'd0, r_comp, 2'd0}
                                            + {7'd0, r_gi[1:0]});

    assign scaled = r_prod[65:16] + $signed(lnt_pkg::POINT_OFFSET);

    assign noise_half = 25'(r_res[0]) + 25'(lnt_pkg::Q_HALF);
    always_comb begin
        if (r_vector_mode) begin
            noise_n = r_res[r_comp];
        end else if (noise_half < 25'sd0) begin
            noise_n = 24'sd0;
        end else if (noise_half > 25'(lnt_pkg::Q_ONE)) begin
            noise_n = 24'(lnt_pkg::Q_ONE);
        end else begin
            noise_n = noise_half[23:0];
        end
    end

    assign off_axis = 2'(r_gi - 3'd2);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SCALE: begin
                mul_a = 33'(r_p[r_axis]);
                mul_b = {1'b0, r_l};
            end
            S_SQ: begin
                mul_a = {17'd0, r_frac[r_axis]};
                mul_b = {17'd0, r_frac[r_axis]};
            end
            S_SM: begin
                mul_a = {17'd0, r_f2};
                mul_b = {15'd0, lnt_pkg::SMOOTH_THREE - {1'b0, r_frac[r_axis], 1'b0}};
            end
            S_CORNER: begin
                mul_a = {16'd0, corner_wt(r_s[0], r_corner[0])};
                mul_b = {16'd0, corner_wt(r_s[1], r_corner[1])};
            end
            S_H2: begin
                mul_a = {16'd0, r_w};
                mul_b = {16'd0, corner_wt(r_s[2], r_corner[2])};
            end
            S_GRD: begin
                if (r_gi >= 3'd2 && r_gi <= 3'd4) begin
                    mul_a = 33'($signed(grad_rdata));
                    mul_b = 33'($signed({r_corner[off_axis], r_frac[off_axis]}));
                end
            end
            S_WD: begin
                mul_a = {16'd0, r_w};
                mul_b = 33'(r_d);
            end
            S_OMUL: begin
                mul_a = {1'b0, r_o};
                mul_b = 33'(noise_n);
            end
            S_LMUL: begin
                mul_a = {1'b0, r_l};
                mul_b = {9'd0, r_freq_gain};
            end
            S_GMUL: begin
                mul_a = {1'b0, r_o};
                mul_b = {9'd0, r_amp_gain};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        if (r_octave_count == 4'd0) begin
            oct_start = 4'd1;
        end else if (32'(r_octave_count) > lnt_pkg::MAX_OCTAVES) begin
            oct_start = 4'(lnt_pkg::MAX_OCTAVES);
        end else begin
            oct_start = r_octave_count;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_fire && in_op == lnt_pkg::OP_EVALUATE) n_state = S_SCALE;
            S_SCALE:   n_state = S_SCALE_W;
            S_SCALE_W: n_state = S_SQ;
            S_SQ:      n_state = S_SQ_W;
            S_SQ_W:    n_state = S_SM;
            S_SM:      n_state = S_SM_W;
            S_SM_W:    n_state = (r_axis == 2'd2) ? S_CORNER : S_SCALE;
            S_CORNER:  n_state = S_H1;
            S_H1:      n_state = S_H2;
            S_H2:      n_state = S_H3;
            S_H3:      n_state = S_GRD;
            S_GRD:     if (r_gi == 3'd5) n_state = S_WD;
            S_WD:      n_state = S_WACC;
            S_WACC: begin
                if (r_vector_mode && r_comp != 2'd2) begin
                    n_state = S_GRD;
                end else if (r_corner == 3'd7) begin
                    n_state = S_OMUL;
                end else begin
                    n_state = S_CORNER;
                end
            end
            S_OMUL:    n_state = S_OACC;
            S_OACC:    n_state = (r_vector_mode && r_comp != 2'd2) ? S_OMUL : S_LMUL;
            S_LMUL:    n_state = S_LUPD;
            S_LUPD:    n_state = S_GMUL;
            S_GMUL:    n_state = S_GUPD;
            S_GUPD:    n_state = (r_oct_left == 4'd1) ? S_OUT : S_SCALE;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p[0]     <= s_axis_tdata[71:40];
                r_p[1]     <= s_axis_tdata[103:72];
                r_p[2]     <= s_axis_tdata[135:104];
                r_l        <= lnt_pkg::Q_ONE;
                r_o        <= lnt_pkg::Q_ONE;
                r_oct_left <= oct_start;
                r_axis     <= 2'd0;
                for (int j = 0; j < 3; j++) begin
                    r_acc[j] <= '0;
                end
            end
            S_SCALE_W: begin
                if (scaled < 50'sd0) begin
                    r_cell[r_axis] <= '0;
                    r_frac[r_axis] <= '0;
                end else if (scaled > 50'(lnt_pkg::POINT_MAX)) begin
                    r_cell[r_axis] <= lnt_pkg::POINT_MAX[30:16];
                    r_frac[r_axis] <= lnt_pkg::POINT_MAX[15:0];
                end else begin
                    r_cell[r_axis] <= scaled[30:16];
                    r_frac[r_axis] <= scaled[15:0];
                end
            end
            S_SQ_W: r_f2 <= r_prod[31:16];
            S_SM_W: begin
                r_s[r_axis] <= r_prod[32:16];
                r_axis      <= 2'(r_axis + 2'd1);
                r_corner    <= 3'd0;
                for (int j = 0; j < 3; j++) begin
                    r_res[j] <= '0;
                end
            end
            S_H1: r_w <= r_prod[32:16];
            S_H3: begin
                r_base <= perm_rdata[7:0];
                r_w    <= r_prod[32:16];
                r_comp <= 2'd0;
                r_gi   <= 3'd0;
            end
            S_GRD: begin
                r_gi <= 3'(r_gi + 3'd1);
                if (r_gi == 3'd1) begin
                    r_d <= 20'($signed(grad_rdata));
                end else if (r_gi >= 3'd3) begin
                    r_d <= r_d + $signed(r_prod[34:15]);
                end
            end
            S_WACC: begin
                r_res[r_comp] <= r_res[r_comp] + $signed(r_prod[39:16]);
                r_gi          <= 3'd0;
                if (r_vector_mode && r_comp != 2'd2) begin
                    r_comp <= 2'(r_comp + 2'd1);
                end else begin
                    r_comp   <= 2'd0;
                    r_corner <= 3'(r_corner + 3'd1);
                end
            end
            S_OACC: begin
                r_acc[r_comp] <= r_acc[r_comp] + $signed(r_prod[63:16]);
                r_comp        <= 2'(r_comp + 2'd1);
            end
            S_LUPD: r_l <= sat_gain(r_prod);
            S_GUPD: begin
                r_o        <= sat_gain(r_prod);
                r_oct_left <= 4'(r_oct_left - 4'd1);
                r_axis     <= 2'd0;
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data <= {sat32(r_acc[2]), sat32(r_acc[1]), sat32(r_acc[0])};
                end
            end
            default: ;
        endcase
    end

    a_oct_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_OUT) |-> (r_oct_left != 4'd0))
        else $error("octave counter reached zero while running");

    a_gi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRD) |-> (r_gi <= 3'd5))
        else $error("gradient step counter out of range");

    a_scalar_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRD && !r_vector_mode) |-> (r_comp == 2'd0))
        else $error("scalar mode visited a vector component");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OMUL || r_state == S_WD) |-> (r_comp <= 2'd2))
        else $error("component index out of range");

endmodule

// File: src/lnt_ram.sv
// Generic simple dual-port RAM with registered read.
module lnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
